### rtl/core/nta_pkg.sv
`timescale 1ns / 1ps
// Shared types and field widths for the nearest target assignment block.
// No dependencies.
package nta_pkg;

  localparam int CNT_W    = 5;   // target_count register
  localparam int SLOT_W   = 4;   // target_slot field
  localparam int DRONE_W  = 8;   // drone_index field
  localparam int POS_W    = 16;  // pos_x / pos_y / pos_z fields
  localparam int ASSIGN_W = 5;   // stored assignment, holds any index below 31
  localparam int OUT_W    = 4;   // assigned_target field
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // scan tag traveling alongside each target entry read
  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic [ASSIGN_W-1:0] idx;
  } nta_tag_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WAIT  = 6'b001000,
    S_HOLD  = 6'b010000,
    S_DONE  = 6'b100000
  } nta_state_t;

endpackage

### rtl/core/nta_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/nta_dist.sv
`timescale 1ns / 1ps
// Squared distance pipeline and running minimum for the target scan.
// Depends on nta_pkg.
module nta_dist import nta_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [3*CW-1:0]     tgt,       // {z, y, x}
  input  logic [CW-1:0]       qx,
  input  logic [CW-1:0]       qy,
  input  logic [CW-1:0]       qz,
  input  nta_tag_t            tag_in,
  output logic                done,
  output logic [ASSIGN_W-1:0] best_idx
);

  localparam int SQ_W  = 2 * CW;
  localparam int SUM_W = SQ_W + 2;

  nta_tag_t tag1, tag2, tag3;
  logic [CW-1:0]    dx, dy, dz;
  logic [SQ_W-1:0]  sqx, sqy, sqz;
  logic [SUM_W-1:0] sum3, best_d;
  logic [ASSIGN_W-1:0] best_i;
  logic [CW-1:0] tx, ty, tz;
  logic take;

  assign tx = tgt[CW-1:0];
  assign ty = tgt[2*CW-1:CW];
  assign tz = tgt[3*CW-1:2*CW];

  // first entry always wins; ties keep the earlier index
  assign take = tag3.first || (sum3 < best_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.vld <= 1'b0;
      tag2.vld <= 1'b0;
      tag3.vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      tag1.vld <= tag_in.vld;
      tag2.vld <= tag1.vld;
      tag3.vld <= tag2.vld;
      done     <= tag3.vld && tag3.last;
    end
    tag1.first <= tag_in.first;
    tag1.last  <= tag_in.last;
    tag1.idx   <= tag_in.idx;
    tag2.first <= tag1.first;
    tag2.last  <= tag1.last;
    tag2.idx   <= tag1.idx;
    tag3.first <= tag2.first;
    tag3.last  <= tag2.last;
    tag3.idx   <= tag2.idx;

    dx <= (tx > qx) ? tx - qx : qx - tx;
    dy <= (ty > qy) ? ty - qy : qy - ty;
    dz <= (tz > qz) ? tz - qz : qz - tz;

    sqx <= SQ_W'(dx) * SQ_W'(dx);
    sqy <= SQ_W'(dy) * SQ_W'(dy);
    sqz <= SQ_W'(dz) * SQ_W'(dz);

    sum3 <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};

    if (tag3.vld && take) begin
      best_d <= sum3;
      best_i <= tag3.idx;
    end
    if (tag3.vld && tag3.last) begin
      best_idx <= take ? tag3.idx : best_i;
    end
  end

endmodule

### rtl/core/nearest_target_assignment.sv
`timescale 1ns / 1ps
// Top level of the nearest target assignment block: sequencer, stores, output.
// Depends on nta_pkg, nta_ram and nta_dist.
//
// Usage:
//   s_* carries load and query requests (tuser = mode). A load writes one
//   target entry into the target RAM (slots from MAX_TARGETS up are dropped)
//   and returns nothing. A query for a live drone scans target entries 0..n-1
//   through the target RAM read port, one entry per cycle, into a 4-stage
//   distance pipeline, then writes the winner into the assignment RAM;
//   n = target_count clamped to 1..min(MAX_TARGETS, 31). A query for a dead
//   drone reads the assignment RAM once. One request is in work at a time;
//   s_tready is high only while the sequencer is idle.
//   m_* carries one result per query from an output register. If the
//   receiver stalls, a finished query waits until that register is free, so
//   the next request is taken as soon as the old result is in the register.
//   cfg_* writes target_count at any time (always ready), meant while idle.
//   Reset: target_count returns to 1 and a clearing pass zeroes the
//   assignment RAM, one entry per cycle, with s_tready low. Target entries
//   are undefined until loaded.
module nearest_target_assignment import nta_pkg::*; #(
  parameter int MAX_TARGETS = 16,
  parameter int MAX_DRONES  = 256,
  parameter int COORD_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: target_slot[3:0], drone_index[11:4], pos_x[27:12], pos_y[43:28],
  //        pos_z[59:44], alive[60], zero fill [63:61]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tuser: mode[0]
  input  logic                  s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: assigned_target[3:0], zero fill [7:4]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // tuser: recomputed[0]
  output logic                  m_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // target_count write
  input  logic [CNT_W-1:0]      cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  localparam int CW    = COORD_BITS < POS_W ? COORD_BITS : POS_W;
  localparam int TW    = MAX_TARGETS > 1 ? $clog2(MAX_TARGETS) : 1;
  localparam int DW    = MAX_DRONES > 1 ? $clog2(MAX_DRONES) : 1;
  localparam int N_CAP = MAX_TARGETS < 31 ? MAX_TARGETS : 31;
  localparam int DRONE_CODES = 1 << DRONE_W;

  // input field split
  logic [SLOT_W-1:0]  in_slot;
  logic [DRONE_W-1:0] in_drone;
  logic [POS_W-1:0]   in_x, in_y, in_z;
  logic               in_alive;

  assign in_slot  = s_tdata[3:0];
  assign in_drone = s_tdata[11:4];
  assign in_x     = s_tdata[27:12];
  assign in_y     = s_tdata[43:28];
  assign in_z     = s_tdata[59:44];
  assign in_alive = s_tdata[60];

  // drone index wraps modulo MAX_DRONES: constant lookup
  logic [DW-1:0] drone_wrap [DRONE_CODES];
  for (genvar i = 0; i < DRONE_CODES; i++) begin : g_wrap
    assign drone_wrap[i] = DW'(i % MAX_DRONES);
  end

  nta_state_t state, state_next;

  logic [CNT_W-1:0]    target_count;
  logic [CNT_W-1:0]    n_eff;
  logic [ASSIGN_W-1:0] last_idx;
  logic [ASSIGN_W-1:0] scan_idx;
  logic [DW-1:0]       clr_idx;
  logic [DW-1:0]       drone_q;
  logic [CW-1:0]       qx, qy, qz;
  logic                alive_q;
  nta_tag_t            rd_tag;
  logic                s_acc, out_free;

  // target RAM
  logic              tgt_we;
  logic [3*CW-1:0]   tgt_rd_data;

  // assignment RAM
  logic                asg_we;
  logic [DW-1:0]       asg_wr_addr;
  logic [ASSIGN_W-1:0] asg_wr_data;
  logic [ASSIGN_W-1:0] asg_rd_data;

  logic                dist_done;
  logic [ASSIGN_W-1:0] dist_best;
  logic [ASSIGN_W-1:0] held_idx;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // count of 0 acts as 1, above the table size (capped at 31) acts as that cap
  always_comb begin
    if (target_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (target_count > CNT_W'(N_CAP)) begin
      n_eff = CNT_W'(N_CAP);
    end else begin
      n_eff = target_count;
    end
  end
  assign last_idx = ASSIGN_W'(n_eff - CNT_W'(1));

  assign held_idx = (asg_rd_data > last_idx) ? last_idx : asg_rd_data;

  assign tgt_we = s_acc && (s_tuser == MODE_LOAD) &&
                  (32'(in_slot) < MAX_TARGETS);

  always_comb begin
    if (state == S_CLEAR) begin
      asg_we      = 1'b1;
      asg_wr_addr = clr_idx;
      asg_wr_data = '0;
    end else begin
      asg_we      = (state == S_DONE) && alive_q && out_free;
      asg_wr_addr = drone_q;
      asg_wr_data = dist_best;
    end
  end

  nta_ram #(
    .WIDTH (3 * CW),
    .DEPTH (MAX_TARGETS)
  ) u_target_ram (
    .clk     (clk),
    .we      (tgt_we),
    .wr_addr (TW'(in_slot)),
    .wr_data ({in_z[CW-1:0], in_y[CW-1:0], in_x[CW-1:0]}),
    .rd_addr (TW'(scan_idx)),
    .rd_data (tgt_rd_data)
  );

  nta_ram #(
    .WIDTH (ASSIGN_W),
    .DEPTH (MAX_DRONES)
  ) u_assign_ram (
    .clk     (clk),
    .we      (asg_we),
    .wr_addr (asg_wr_addr),
    .wr_data (asg_wr_data),
    .rd_addr (drone_q),
    .rd_data (asg_rd_data)
  );

  nta_dist #(
    .CW (CW)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .tgt      (tgt_rd_data),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .tag_in   (rd_tag),
    .done     (dist_done),
    .best_idx (dist_best)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == DW'(MAX_DRONES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_acc && (s_tuser == MODE_QUERY)) begin
          state_next = in_alive ? S_SCAN : S_HOLD;
        end
      end
      S_SCAN: begin
        if (scan_idx == last_idx) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (dist_done) state_next = S_DONE;
      end
      S_HOLD: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      target_count <= CNT_W'(1);
      clr_idx      <= '0;
      scan_idx     <= '0;
      rd_tag.vld   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) target_count <= cfg_data;

      if (state == S_CLEAR) clr_idx <= clr_idx + DW'(1);

      if (state == S_SCAN) begin
        scan_idx <= scan_idx + ASSIGN_W'(1);
      end else begin
        scan_idx <= '0;
      end
      rd_tag.vld <= (state == S_SCAN);

      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end

    // tag lines up with the registered RAM read of this entry
    rd_tag.first <= (scan_idx == '0);
    rd_tag.last  <= (scan_idx == last_idx);
    rd_tag.idx   <= scan_idx;

    if (s_acc && (s_tuser == MODE_QUERY)) begin
      drone_q <= drone_wrap[in_drone];
      qx      <= in_x[CW-1:0];
      qy      <= in_y[CW-1:0];
      qz      <= in_z[CW-1:0];
      alive_q <= in_alive;
    end

    if (state == S_DONE && out_free) begin
      m_tdata <= {(OUT_DATA_W - OUT_W)'(0),
                  alive_q ? dist_best[OUT_W-1:0] : held_idx[OUT_W-1:0]};
      m_tuser <= alive_q;
    end
  end

endmodule
